// ----- hdl/macro_byte_stream_decoder_unit_macros.svh -----
// Assertion helpers for the macro byte stream decoder.
// Both expect clk and rst in scope; rst masks the check.
`ifndef MACRO_BYTE_STREAM_DECODER_UNIT_MACROS_SVH
`define MACRO_BYTE_STREAM_DECODER_UNIT_MACROS_SVH

// Same-cycle implication.
`define MBSD_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define MBSD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/mbsd_pkg.sv -----
package mbsd_pkg;

  localparam int QUEUE_DEPTH = 2;

  localparam logic OP_START = 1'b0;
  localparam logic OP_BYTE  = 1'b1;

  localparam logic [7:0] MACRO_COUNT_RESET = 8'd16;
  localparam logic [7:0] BYTE_PREFIX       = 8'h01;
  localparam logic [7:0] BYTE_EXT_HIGH     = 8'hFF;

  // operation selected by the byte after the prefix
  localparam logic [2:0] CMD_TAP      = 3'd1;
  localparam logic [2:0] CMD_DOWN     = 3'd2;
  localparam logic [2:0] CMD_UP       = 3'd3;
  localparam logic [2:0] CMD_DELAY    = 3'd4;
  localparam logic [2:0] CMD_EXT_TAP  = 3'd5;
  localparam logic [2:0] CMD_EXT_DOWN = 3'd6;
  localparam logic [2:0] CMD_EXT_UP   = 3'd7;

  localparam logic [3:0] EV_CHAR     = 4'd0;
  localparam logic [3:0] EV_TAP      = 4'd1;
  localparam logic [3:0] EV_DOWN     = 4'd2;
  localparam logic [3:0] EV_UP       = 4'd3;
  localparam logic [3:0] EV_EXT_TAP  = 4'd4;
  localparam logic [3:0] EV_EXT_DOWN = 4'd5;
  localparam logic [3:0] EV_EXT_UP   = 4'd6;
  localparam logic [3:0] EV_DELAY    = 4'd7;
  localparam logic [3:0] EV_DONE     = 4'd8;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_SKIP,
    PH_TOP,
    PH_OPCODE,
    PH_ARG1,
    PH_ARG2
  } phase_t;

  typedef struct packed {
    logic       op;
    logic [7:0] macro_id;
    logic [7:0] data_byte;
  } item_t;

  typedef struct packed {
    logic [3:0]  event_res;
    logic [15:0] code;
    logic [15:0] delay_ms;
  } result_t;

  // classified request handed from front to back
  typedef struct packed {
    logic       op;
    logic       start_ok;
    logic       id_zero;
    logic [7:0] macro_id;
    logic [7:0] data_byte;
    logic       byte_zero;
    logic       byte_prefix;
    logic       byte_cmd;
  } token_t;

  typedef struct packed {
    logic tok_pop;
    logic res_push;
    logic playing;
  } back_ctl_t;

endpackage

// ----- hdl/macro_byte_stream_decoder_unit.sv -----
// Channel    Handshake          Payload
// requests   push / full        item   (op, macro_id, data_byte)
// results    empty / pop        result (event_res, code, delay_ms)
// config     cfg_wr_en          cfg_wr_data (macro_count)
//
// One request per cycle while the result queue has room; results are registered there.
// The parser state machine sets the rate, one byte a cycle when not stalled.
// rst clears both queues, the parser state and sets macro_count to 16.
// Requests queue up while results are held back; full rises once the
// request queue fills behind a full result queue.
module macro_byte_stream_decoder_unit #(
  parameter int QUEUE_DEPTH = mbsd_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  mbsd_pkg::item_t   item,
  output logic              empty,
  input  logic              pop,
  output mbsd_pkg::result_t result,
  input  logic              cfg_wr_en,
  input  logic [7:0]        cfg_wr_data
);

  `include "macro_byte_stream_decoder_unit_macros.svh"

  mbsd_pkg::token_t    tok_in;
  mbsd_pkg::token_t    tok;
  logic                tok_empty;
  mbsd_pkg::result_t   res_in;
  logic                res_full;
  mbsd_pkg::back_ctl_t ctl;

  mbsd_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .item        (item),
    .tok         (tok_in)
  );

  mbsd_fifo #(
    .WIDTH ($bits(mbsd_pkg::token_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_tok_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (tok_in),
    .full  (full),
    .pop   (ctl.tok_pop),
    .rdata (tok),
    .empty (tok_empty)
  );

  mbsd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .tok_valid (!tok_empty),
    .tok       (tok),
    .res_full  (res_full),
    .res       (res_in),
    .ctl       (ctl)
  );

  mbsd_fifo #(
    .WIDTH ($bits(mbsd_pkg::result_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_res_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (ctl.res_push),
    .wdata (res_in),
    .full  (res_full),
    .pop   (pop),
    .rdata (result),
    .empty (empty)
  );

  `MBSD_ASSERT_SAME(a_res_no_overflow, ctl.res_push, !res_full, "result queue overflow")
  `MBSD_ASSERT_NEXT(a_reject_goes_idle,
    ctl.tok_pop && tok.op == mbsd_pkg::OP_START && !tok.start_ok,
    !ctl.playing, "rejected start left parser busy")
  `MBSD_ASSERT_NEXT(a_done_goes_idle,
    ctl.res_push && res_in.event_res == mbsd_pkg::EV_DONE,
    !ctl.playing, "done without returning idle")
  `MBSD_ASSERT_SAME(a_idle_byte_silent,
    ctl.tok_pop && tok.op == mbsd_pkg::OP_BYTE && !ctl.playing,
    !ctl.res_push, "byte while idle produced a result")

endmodule

// ----- hdl/mbsd_fifo.sv -----
// Small register queue, DEPTH >= 2. No write while full, no read while empty.
module mbsd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = mbsd_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- hdl/mbsd_front.sv -----
// Holds macro_count and classifies each incoming request.
module mbsd_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic [7:0]       cfg_wr_data,
  input  mbsd_pkg::item_t  item,
  output mbsd_pkg::token_t tok
);

  logic [7:0] macro_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      macro_count <= mbsd_pkg::MACRO_COUNT_RESET;
    end else if (cfg_wr_en) begin
      macro_count <= cfg_wr_data;
    end
  end

  always_comb begin
    tok.op          = item.op;
    // start is refused unless id fits and the buffer ends in a terminator
    tok.start_ok    = (item.macro_id < macro_count) && (item.data_byte == 8'h00);
    tok.id_zero     = (item.macro_id == 8'h00);
    tok.macro_id    = item.macro_id;
    tok.data_byte   = item.data_byte;
    tok.byte_zero   = (item.data_byte == 8'h00);
    tok.byte_prefix = (item.data_byte == mbsd_pkg::BYTE_PREFIX);
    tok.byte_cmd    = (item.data_byte != 8'h00) && (item.data_byte[7:3] == 5'd0);
  end

endmodule

// ----- hdl/mbsd_back.sv -----
// Parser: takes one request per cycle while the result queue has room.
module mbsd_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                tok_valid,
  input  mbsd_pkg::token_t    tok,
  input  logic                res_full,
  output mbsd_pkg::result_t   res,
  output mbsd_pkg::back_ctl_t ctl
);

  mbsd_pkg::phase_t phase;
  mbsd_pkg::phase_t phase_next;
  logic [7:0]       skips_left;
  logic [7:0]       skips_left_next;
  logic [2:0]       command_byte;
  logic [2:0]       command_byte_next;
  logic [7:0]       first_argument;
  logic [7:0]       first_argument_next;
  logic             fire;
  logic             res_push;
  logic [7:0]       d0m;
  logic [7:0]       d1m;
  logic [15:0]      delay_val;
  logic [15:0]      ext_code;
  logic [3:0]       key_event;

  assign fire = tok_valid && !res_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= mbsd_pkg::PH_IDLE;
      skips_left     <= '0;
      command_byte   <= '0;
      first_argument <= '0;
    end else begin
      phase          <= phase_next;
      skips_left     <= skips_left_next;
      command_byte   <= command_byte_next;
      first_argument <= first_argument_next;
    end
  end

  always_comb begin
    phase_next          = phase;
    skips_left_next     = skips_left;
    command_byte_next   = command_byte;
    first_argument_next = first_argument;
    if (fire) begin
      if (tok.op == mbsd_pkg::OP_START) begin
        if (!tok.start_ok) begin
          phase_next = mbsd_pkg::PH_IDLE;
        end else begin
          skips_left_next = tok.macro_id;
          phase_next      = tok.id_zero ? mbsd_pkg::PH_TOP : mbsd_pkg::PH_SKIP;
        end
      end else begin
        unique case (phase)
          mbsd_pkg::PH_IDLE: begin
            phase_next = mbsd_pkg::PH_IDLE;
          end
          mbsd_pkg::PH_SKIP: begin
            if (tok.byte_zero) begin
              skips_left_next = skips_left - 8'd1;
              if (skips_left == 8'd1) begin
                phase_next = mbsd_pkg::PH_TOP;
              end
            end
          end
          mbsd_pkg::PH_TOP: begin
            if (tok.byte_zero) begin
              phase_next = mbsd_pkg::PH_IDLE;
            end else if (tok.byte_prefix) begin
              phase_next = mbsd_pkg::PH_OPCODE;
            end
          end
          mbsd_pkg::PH_OPCODE: begin
            if (tok.byte_zero) begin
              phase_next = mbsd_pkg::PH_IDLE;
            end else if (tok.byte_cmd) begin
              command_byte_next = tok.data_byte[2:0];
              phase_next        = mbsd_pkg::PH_ARG1;
            end else begin
              phase_next = mbsd_pkg::PH_TOP;
            end
          end
          mbsd_pkg::PH_ARG1: begin
            case (command_byte) inside
              mbsd_pkg::CMD_TAP, mbsd_pkg::CMD_DOWN, mbsd_pkg::CMD_UP: begin
                phase_next = mbsd_pkg::PH_TOP;
              end
              mbsd_pkg::CMD_DELAY: begin
                first_argument_next = tok.data_byte;
                phase_next          = mbsd_pkg::PH_ARG2;
              end
              default: begin
                // zero low byte aborts the extended key
                if (tok.byte_zero) begin
                  phase_next = mbsd_pkg::PH_TOP;
                end else begin
                  first_argument_next = tok.data_byte;
                  phase_next          = mbsd_pkg::PH_ARG2;
                end
              end
            endcase
          end
          mbsd_pkg::PH_ARG2: begin
            if (command_byte == mbsd_pkg::CMD_DELAY &&
                (first_argument == 8'h00 || tok.byte_zero)) begin
              phase_next = mbsd_pkg::PH_IDLE;
            end else begin
              phase_next = mbsd_pkg::PH_TOP;
            end
          end
          default: begin
            phase_next = mbsd_pkg::PH_IDLE;
          end
        endcase
      end
    end
  end

  // (d0-1) + (d1-1)*255 as shift and subtract
  assign d0m       = first_argument - 8'd1;
  assign d1m       = tok.data_byte - 8'd1;
  assign delay_val = {d1m, 8'h00} - {8'h00, d1m} + {8'h00, d0m};

  // high byte 0xFF with nonzero low byte remaps to low << 8
  assign ext_code = (tok.data_byte == mbsd_pkg::BYTE_EXT_HIGH) ?
                    {first_argument, 8'h00} : {tok.data_byte, first_argument};

  always_comb begin
    case (command_byte)
      mbsd_pkg::CMD_TAP:      key_event = mbsd_pkg::EV_TAP;
      mbsd_pkg::CMD_DOWN:     key_event = mbsd_pkg::EV_DOWN;
      mbsd_pkg::CMD_UP:       key_event = mbsd_pkg::EV_UP;
      mbsd_pkg::CMD_EXT_TAP:  key_event = mbsd_pkg::EV_EXT_TAP;
      mbsd_pkg::CMD_EXT_DOWN: key_event = mbsd_pkg::EV_EXT_DOWN;
      mbsd_pkg::CMD_EXT_UP:   key_event = mbsd_pkg::EV_EXT_UP;
      default:                key_event = mbsd_pkg::EV_DELAY;
    endcase
  end

  always_comb begin
    res_push      = 1'b0;
    res.event_res = mbsd_pkg::EV_DONE;
    res.code      = 16'h0000;
    res.delay_ms  = 16'h0000;
    if (fire && tok.op == mbsd_pkg::OP_BYTE) begin
      unique case (phase)
        mbsd_pkg::PH_TOP: begin
          if (tok.byte_zero) begin
            res_push = 1'b1;
          end else if (!tok.byte_prefix) begin
            res_push      = 1'b1;
            res.event_res = mbsd_pkg::EV_CHAR;
            res.code      = {8'h00, tok.data_byte};
          end
        end
        mbsd_pkg::PH_OPCODE: begin
          res_push = tok.byte_zero;
        end
        mbsd_pkg::PH_ARG1: begin
          if (command_byte == mbsd_pkg::CMD_TAP || command_byte == mbsd_pkg::CMD_DOWN ||
              command_byte == mbsd_pkg::CMD_UP) begin
            res_push      = !tok.byte_zero;
            res.event_res = key_event;
            res.code      = {8'h00, tok.data_byte};
          end
        end
        mbsd_pkg::PH_ARG2: begin
          if (command_byte == mbsd_pkg::CMD_DELAY) begin
            res_push = 1'b1;
            if (first_argument != 8'h00 && !tok.byte_zero) begin
              res.event_res = mbsd_pkg::EV_DELAY;
              res.delay_ms  = delay_val;
            end
          end else if (!tok.byte_zero) begin
            res_push      = 1'b1;
            res.event_res = key_event;
            res.code      = ext_code;
          end
        end
        default: begin
          res_push = 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    ctl.tok_pop  = fire;
    ctl.res_push = res_push;
    ctl.playing  = (phase != mbsd_pkg::PH_IDLE);
  end

endmodule
